[rtl/pp4_pkg.sv]
// Shared request codes, command layout and colour encoding for the pixel plotter.
package pp4_pkg;

  // Request types on the input channel
  localparam logic [1:0] REQ_DRAW_RGB  = 2'd0;
  localparam logic [1:0] REQ_DRAW_SAT  = 2'd1;
  localparam logic [1:0] REQ_READ_ROT  = 2'd2;
  localparam logic [1:0] REQ_READ_PHYS = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ROTATION   = 2'd0;
  localparam logic [1:0] CFG_RED_CODE   = 2'd1;
  localparam logic [1:0] CFG_WHITE_CODE = 2'd2;

  // Quarter-turn settings
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // Command kinds passed from front to back
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CONST = 2'd2;

  // Register reset values
  localparam logic [1:0]  ROTATION_RESET   = 2'd0;
  localparam logic [15:0] RED_CODE_RESET   = 16'hF800;
  localparam logic [15:0] WHITE_CODE_RESET = 16'hFFFF;

  // Fixed results for reads that miss the store
  localparam logic [7:0] OUT_OF_FRAME_VALUE = 8'hFF;
  localparam logic [7:0] OUT_OF_STORE_VALUE = 8'h00;

  // Queue depths
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  // Control part of one command; the byte address travels beside it
  typedef struct packed {
    logic [1:0] kind;
    logic       odd;
    logic [3:0] nib;
    logic [7:0] value;
  } cmd_ctl_t;

  localparam int CMD_CTL_W = $bits(cmd_ctl_t);

  // RGB565 to nibble: inverted top green bits, red flag when red dominates
  function automatic logic [3:0] encode_rgb(input logic [15:0] c);
    logic [2:0] r;
    logic [2:0] g;
    logic [2:0] b;
    r = c[15:13];
    g = c[10:8];
    b = c[4:2];
    return {(r > g) && (r > b), ~g};
  endfunction

endpackage

[rtl/pp4_queue.sv]
// Small register queue used for commands and for results.
module pp4_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           in_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           out_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    level;
  logic             do_push;
  logic             do_pop;

  assign full     = (level == CW'(DEPTH));
  assign empty    = (level == '0);
  assign count    = level;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign out_data = slots[rd_ptr];

  // Store an incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // Advance pointers and the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        level <= level + CW'(1);
      end else if (do_pop && !do_push) begin
        level <= level - CW'(1);
      end
    end
  end

endmodule

[rtl/pp4_front.sv]
// Front end: configuration registers, bounds check, rotation mapping and encoding.
module pp4_front #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 128,
  parameter int AW           = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  in_accept,
  input  logic [1:0]            req_type,
  input  logic signed [15:0]    pos_x,
  input  logic signed [15:0]    pos_y,
  input  logic [15:0]           colour,
  input  logic [3:0]            level,
  output logic                  cmd_push,
  output pp4_pkg::cmd_ctl_t     cmd_ctl,
  output logic [AW-1:0]         cmd_addr
);

  localparam int MAX_DIM     = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int CW          = $clog2(MAX_DIM);
  localparam int AFW         = $clog2(FRAME_WIDTH * FRAME_HEIGHT) + 1;
  localparam int STORE_BYTES = (FRAME_WIDTH / 2) * FRAME_HEIGHT;

  logic [1:0]     rotation;
  logic [15:0]    red_code;
  logic [15:0]    white_code;

  logic [15:0]    x_u;
  logic [15:0]    y_u;
  logic [15:0]    rot_w;
  logic [15:0]    rot_h;
  logic           rot_in;
  logic           phys_in;
  logic [CW-1:0]  xc;
  logic [CW-1:0]  yc;
  logic [CW-1:0]  mx;
  logic [CW-1:0]  my;
  logic [CW-1:0]  px;
  logic [CW-1:0]  py;
  logic [AFW-1:0] row_base;
  logic [AFW-1:0] full_addr;
  logic           addr_ok;
  logic [2:0]     sat;
  logic [3:0]     sat_nib;
  logic           want_push;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation   <= pp4_pkg::ROTATION_RESET;
      red_code   <= pp4_pkg::RED_CODE_RESET;
      white_code <= pp4_pkg::WHITE_CODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pp4_pkg::CFG_ROTATION:   rotation   <= cfg_data[1:0];
        pp4_pkg::CFG_RED_CODE:   red_code   <= cfg_data;
        pp4_pkg::CFG_WHITE_CODE: white_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Check bounds against rotated and physical frame sizes
  assign x_u     = $unsigned(pos_x);
  assign y_u     = $unsigned(pos_y);
  assign rot_w   = rotation[0] ? 16'(FRAME_HEIGHT) : 16'(FRAME_WIDTH);
  assign rot_h   = rotation[0] ? 16'(FRAME_WIDTH) : 16'(FRAME_HEIGHT);
  assign rot_in  = !pos_x[15] && (x_u < rot_w) && !pos_y[15] && (y_u < rot_h);
  assign phys_in = !pos_x[15] && (x_u < 16'(FRAME_WIDTH)) &&
                   !pos_y[15] && (y_u < 16'(FRAME_HEIGHT));
  assign xc      = x_u[CW-1:0];
  assign yc      = y_u[CW-1:0];

  // Map rotated coordinates back to the physical frame
  always_comb begin
    case (rotation)
      pp4_pkg::ROT_90: begin
        mx = CW'(FRAME_WIDTH - 1) - yc;
        my = xc;
      end
      pp4_pkg::ROT_180: begin
        mx = CW'(FRAME_WIDTH - 1) - xc;
        my = CW'(FRAME_HEIGHT - 1) - yc;
      end
      pp4_pkg::ROT_270: begin
        mx = yc;
        my = CW'(FRAME_HEIGHT - 1) - xc;
      end
      default: begin
        mx = xc;
        my = yc;
      end
    endcase
  end

  assign px = (req_type == pp4_pkg::REQ_READ_PHYS) ? xc : mx;
  assign py = (req_type == pp4_pkg::REQ_READ_PHYS) ? yc : my;

  // Form the byte address, two pixels to a byte
  assign row_base  = AFW'(py) * AFW'(FRAME_WIDTH);
  assign full_addr = AFW'(px >> 1) + (row_base >> 1);
  assign addr_ok   = (full_addr < AFW'(STORE_BYTES));
  assign cmd_addr  = full_addr[AW-1:0];

  // Encode a saturation draw
  always_comb begin
    sat = level[3:1];
    if (colour == white_code) begin
      sat = ~sat;
    end
    sat_nib = {colour == red_code, sat};
  end

  // Classify the request into a command
  always_comb begin
    cmd_ctl.kind  = pp4_pkg::CMD_READ;
    cmd_ctl.odd   = px[0];
    cmd_ctl.nib   = 4'h0;
    cmd_ctl.value = pp4_pkg::OUT_OF_STORE_VALUE;
    want_push     = 1'b1;
    unique case (req_type) inside
      pp4_pkg::REQ_DRAW_RGB, pp4_pkg::REQ_DRAW_SAT: begin
        cmd_ctl.kind = pp4_pkg::CMD_WRITE;
        cmd_ctl.nib  = (req_type == pp4_pkg::REQ_DRAW_RGB) ?
                       pp4_pkg::encode_rgb(colour) : sat_nib;
        want_push    = rot_in && addr_ok;
      end
      pp4_pkg::REQ_READ_ROT: begin
        if (!(rot_in && addr_ok)) begin
          cmd_ctl.kind = pp4_pkg::CMD_CONST;
        end
      end
      default: begin
        if (!phys_in) begin
          cmd_ctl.kind  = pp4_pkg::CMD_CONST;
          cmd_ctl.value = pp4_pkg::OUT_OF_FRAME_VALUE;
        end else if (!addr_ok) begin
          cmd_ctl.kind = pp4_pkg::CMD_CONST;
        end
      end
    endcase
  end

  assign cmd_push = in_accept && want_push;

endmodule

[rtl/pp4_back.sv]
// Back end: clearing pass, nibble stores and the read stage feeding results.
module pp4_back #(
  parameter int STORE_BYTES = 16384,
  parameter int AW          = 14,
  parameter int RES_DEPTH   = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  pp4_pkg::cmd_ctl_t              cmd_ctl,
  input  logic [AW-1:0]                  cmd_addr,
  output logic                           cmd_pop,
  input  logic [$clog2(RES_DEPTH+1)-1:0] res_count,
  output logic                           res_push,
  output logic [7:0]                     res_data,
  output logic                           clearing
);

  localparam int RCW = $clog2(RES_DEPTH + 1);

  logic [3:0]    hi_mem [STORE_BYTES];
  logic [3:0]    lo_mem [STORE_BYTES];
  logic [3:0]    hi_q;
  logic [3:0]    lo_q;
  logic [AW-1:0] clr_addr;

  logic          is_wr;
  logic          is_rd;
  logic          is_const;
  logic          space;
  logic          issue;
  logic          hi_we;
  logic          lo_we;
  logic [AW-1:0] wr_addr;
  logic [3:0]    wr_nib;

  logic          st_valid;
  logic          st_const;
  logic          st_odd;
  logic [7:0]    st_value;

  // Decode the command kind
  always_comb begin
    is_wr    = 1'b0;
    is_rd    = 1'b0;
    is_const = 1'b0;
    unique case (cmd_ctl.kind)
      pp4_pkg::CMD_WRITE: is_wr    = 1'b1;
      pp4_pkg::CMD_READ:  is_rd    = 1'b1;
      pp4_pkg::CMD_CONST: is_const = 1'b1;
      default: ;
    endcase
  end

  // Issue a read or constant only when the result queue can take what is in flight; writes need no room
  assign space   = ((RCW + 1)'(res_count) + (RCW + 1)'(st_valid)) < (RCW + 1)'(RES_DEPTH);
  assign issue   = cmd_valid && !clearing && (is_wr || space);
  assign cmd_pop = issue;

  // Select write port: clearing pass or a draw
  assign hi_we   = clearing || (issue && is_wr && !cmd_ctl.odd);
  assign lo_we   = clearing || (issue && is_wr && cmd_ctl.odd);
  assign wr_addr = clearing ? clr_addr : cmd_addr;
  assign wr_nib  = clearing ? 4'h0 : cmd_ctl.nib;

  // Step the clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(STORE_BYTES - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // High-nibble store
  always_ff @(posedge clk) begin
    if (hi_we) begin
      hi_mem[wr_addr] <= wr_nib;
    end
    if (issue && is_rd) begin
      hi_q <= hi_mem[cmd_addr];
    end
  end

  // Low-nibble store
  always_ff @(posedge clk) begin
    if (lo_we) begin
      lo_mem[wr_addr] <= wr_nib;
    end
    if (issue && is_rd) begin
      lo_q <= lo_mem[cmd_addr];
    end
  end

  // Hold read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= issue && (is_rd || is_const);
    end
  end

  // Hold read stage payload
  always_ff @(posedge clk) begin
    if (issue) begin
      st_const <= is_const;
      st_odd   <= cmd_ctl.odd;
      st_value <= cmd_ctl.value;
    end
  end

  assign res_push = st_valid;
  assign res_data = st_const ? st_value : {4'h0, st_odd ? lo_q : hi_q};

endmodule

[rtl/packed_4bpp_pixel_plotter.sv]
// Top level of the packed 4-bit-per-pixel plotter.
//
// Input side is a queue: present a request with push while full is low.
// Draw requests (types 0 and 1) update one pixel and give no result; read
// requests (types 2 and 3) give exactly one pixel_value each, in order.
// Result side is a queue: pixel_value is valid while empty is low and is
// taken with pop. Configuration writes use cfg_valid/cfg_ready with
// cfg_index 0 rotation, 1 red colour code, 2 white colour code; cfg_ready
// is always high. The user must see that writes are made only while no
// request is in flight; the block does not enforce this. A read result
// passes through a two-entry command queue, the store's registered read
// and a four-entry result queue. The back end takes one request per cycle
// while no clearing pass runs and, for reads, the result queue has room.
// Reset clears registers and starts a clearing pass over the store of
// (FRAME_WIDTH/2)*FRAME_HEIGHT bytes (16384 at the default size), during
// which full stays high. If the receiver stops popping, the result queue
// fills, reads stop issuing, the command queue fills and full rises.
module packed_4bpp_pixel_plotter #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        colour,
  input  logic [3:0]         level,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         pixel_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int STORE_BYTES = (FRAME_WIDTH / 2) * FRAME_HEIGHT;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CMD_W       = pp4_pkg::CMD_CTL_W + AW;
  localparam int RCW         = $clog2(pp4_pkg::RES_DEPTH + 1);

  logic              in_accept;
  logic              clearing;
  logic              cmd_push;
  pp4_pkg::cmd_ctl_t cmd_ctl_in;
  logic [AW-1:0]     cmd_addr_in;
  logic              cmd_full;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [CMD_W-1:0]  cmd_out;
  pp4_pkg::cmd_ctl_t cmd_ctl_out;
  logic [AW-1:0]     cmd_addr_out;
  logic              res_push;
  logic [7:0]        res_data;
  logic              res_full;
  logic [RCW-1:0]    res_count;

  // Refuse requests while the command queue is full or the store is clearing
  assign full      = cmd_full || clearing;
  assign in_accept = push && !full;

  pp4_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .AW           (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .req_type  (req_type),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .colour    (colour),
    .level     (level),
    .cmd_push  (cmd_push),
    .cmd_ctl   (cmd_ctl_in),
    .cmd_addr  (cmd_addr_in)
  );

  pp4_queue #(
    .WIDTH (CMD_W),
    .DEPTH (pp4_pkg::CMD_DEPTH)
  ) u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .in_data  ({cmd_ctl_in, cmd_addr_in}),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .out_data (cmd_out),
    .empty    (cmd_empty),
    .count    ()
  );

  // Split the queued command
  assign cmd_ctl_out  = pp4_pkg::cmd_ctl_t'(cmd_out[CMD_W-1:AW]);
  assign cmd_addr_out = cmd_out[AW-1:0];

  pp4_back #(
    .STORE_BYTES (STORE_BYTES),
    .AW          (AW),
    .RES_DEPTH   (pp4_pkg::RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd_ctl   (cmd_ctl_out),
    .cmd_addr  (cmd_addr_out),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data),
    .clearing  (clearing)
  );

  pp4_queue #(
    .WIDTH (8),
    .DEPTH (pp4_pkg::RES_DEPTH)
  ) u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .in_data  (res_data),
    .full     (res_full),
    .pop      (pop),
    .out_data (pixel_value),
    .empty    (empty),
    .count    (res_count)
  );

  // No request is taken while the clearing pass runs
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> full)
    else $error("request accepted during clearing pass");

  // Credit check keeps the result queue from overflowing
  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // Back end only takes commands that exist
  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

  // No command issues while clearing
  a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cmd_pop)
    else $error("command issued during clearing pass");

endmodule

[dv/packed_4bpp_pixel_plotter_tb.sv]
// Self-checking testbench for the packed 4bpp pixel plotter: directed and random requests.
module packed_4bpp_pixel_plotter_tb;

  localparam int FRAME_W     = 256;
  localparam int FRAME_H     = 128;
  localparam int STORE_BYTES = (FRAME_W / 2) * FRAME_H;
  localparam int QUIET_LIMIT = 60000;
  localparam int SETTLE_CYC  = 8;
  localparam int PHASE_REQS  = 165;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        colour;
    logic [3:0]         level;
  } plot_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         req_type;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        colour;
  logic [3:0]         level;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         pixel_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = pp4_pkg::CFG_ROTATION;
  logic [15:0]        cfg_data = '0;

  plot_req_t cur_req = '0;

  // Shadow state of the plotter
  logic [7:0]  frame_bytes [STORE_BYTES];
  logic [1:0]  rot_setting;
  logic [15:0] red_code;
  logic [15:0] white_code;

  plot_req_t   pending_reqs [$];
  logic [7:0]  expected_pixels [$];
  int          mismatch_count = 0;
  int          pixels_checked = 0;

  assign req_type = cur_req.kind;
  assign pos_x    = cur_req.pos_x;
  assign pos_y    = cur_req.pos_y;
  assign colour   = cur_req.colour;
  assign level    = cur_req.level;

  packed_4bpp_pixel_plotter #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .colour     (colour),
    .level      (level),
    .empty      (empty),
    .pop        (pop),
    .pixel_value(pixel_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted request to the shadow store and queue its pixel, if any
  task automatic plot_pixel_request(input plot_req_t rq);
    int          x;
    int          y;
    int          t;
    int          w;
    int          h;
    int unsigned addr;
    bit          in_frame;
    bit          is_read;
    logic [2:0]  r;
    logic [2:0]  g;
    logic [2:0]  b;
    logic [2:0]  sat;
    logic [3:0]  nib;
    logic [7:0]  pixel;
    x = int'($signed(rq.pos_x));
    y = int'($signed(rq.pos_y));
    is_read = (rq.kind == pp4_pkg::REQ_READ_ROT) || (rq.kind == pp4_pkg::REQ_READ_PHYS);
    if (rq.kind == pp4_pkg::REQ_READ_PHYS) begin
      in_frame = (x >= 0) && (x < FRAME_W) && (y >= 0) && (y < FRAME_H);
      pixel = pp4_pkg::OUT_OF_FRAME_VALUE;
    end else begin
      w = rot_setting[0] ? FRAME_H : FRAME_W;
      h = rot_setting[0] ? FRAME_W : FRAME_H;
      in_frame = (x >= 0) && (x < w) && (y >= 0) && (y < h);
      pixel = 8'h00;
      // Map rotated coordinates back onto the physical frame
      if (in_frame) begin
        case (rot_setting)
          pp4_pkg::ROT_90: begin
            t = x;
            x = FRAME_W - 1 - y;
            y = t;
          end
          pp4_pkg::ROT_180: begin
            x = FRAME_W - 1 - x;
            y = FRAME_H - 1 - y;
          end
          pp4_pkg::ROT_270: begin
            t = x;
            x = y;
            y = FRAME_H - 1 - t;
          end
          default: ;
        endcase
      end
    end
    if (in_frame) begin
      addr = $unsigned(x / 2 + (y * FRAME_W) / 2);
      if (addr >= STORE_BYTES) begin
        pixel = pp4_pkg::OUT_OF_STORE_VALUE;
      end else if (is_read) begin
        pixel = {4'h0, x[0] ? frame_bytes[addr][3:0] : frame_bytes[addr][7:4]};
      end else begin
        if (rq.kind == pp4_pkg::REQ_DRAW_RGB) begin
          r = rq.colour[15:13];
          g = rq.colour[10:8];
          b = rq.colour[4:2];
          nib = {(r > g) && (r > b), ~g};
        end else begin
          sat = rq.level[3:1];
          if (rq.colour == white_code) sat = ~sat;
          nib = {rq.colour == red_code, sat};
        end
        if (x[0]) frame_bytes[addr] = {frame_bytes[addr][7:4], nib};
        else frame_bytes[addr] = {nib, frame_bytes[addr][3:0]};
      end
    end
    if (is_read) expected_pixels.push_back(pixel);
  endtask

  task automatic queue_request(input logic [1:0] kind, input logic [15:0] x,
                               input logic [15:0] y, input logic [15:0] c,
                               input logic [3:0] lvl);
    plot_req_t rq;
    rq.kind   = kind;
    rq.pos_x  = x;
    rq.pos_y  = y;
    rq.colour = c;
    rq.level  = lvl;
    pending_reqs.push_back(rq);
  endtask

  // Pick a coordinate on or just past a frame boundary, or at a field extreme
  function automatic logic [15:0] boundary_coord(input int lim);
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'(lim - 1);
      3: return 16'(lim);
      4: return 16'hFFFF;
      5: return 16'h8000;
      default: return 16'h7FFF;
    endcase
  endfunction

  // Build one random request, biased to land inside the rotated frame
  function automatic plot_req_t random_request(input logic [1:0] rot,
                                               input logic [15:0] red,
                                               input logic [15:0] white);
    plot_req_t rq;
    int        w;
    int        h;
    int        pick;
    w = rot[0] ? FRAME_H : FRAME_W;
    h = rot[0] ? FRAME_W : FRAME_H;
    pick = int'($urandom_range(0, 99));
    if (pick < 30) rq.kind = pp4_pkg::REQ_DRAW_RGB;
    else if (pick < 55) rq.kind = pp4_pkg::REQ_DRAW_SAT;
    else if (pick < 80) rq.kind = pp4_pkg::REQ_READ_ROT;
    else rq.kind = pp4_pkg::REQ_READ_PHYS;
    pick = int'($urandom_range(0, 9));
    if (pick < 4) begin
      rq.pos_x = 16'($urandom_range(0, w - 1));
      rq.pos_y = 16'($urandom_range(0, h - 1));
    end else if (pick < 7) begin
      // small corner window so draws and reads keep hitting the same bytes
      rq.pos_x = 16'($urandom_range(0, 5));
      rq.pos_y = 16'($urandom_range(0, 3));
    end else if (pick < 8) begin
      rq.pos_x = boundary_coord(w);
      rq.pos_y = boundary_coord(h);
    end else begin
      rq.pos_x = 16'($urandom);
      rq.pos_y = 16'($urandom);
    end
    pick = int'($urandom_range(0, 9));
    if (pick < 3) rq.colour = red;
    else if (pick < 5) rq.colour = white;
    else rq.colour = 16'($urandom);
    rq.level = 4'($urandom);
    return rq;
  endfunction

  // Wait until every request is taken and every pixel returned, then settle;
  // sample between edges so the sender's latest update is seen
  task automatic drain_plotter();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || push || expected_pixels.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Offer one register write and hold it until taken; valid stays high
  task automatic write_config(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      pp4_pkg::CFG_ROTATION: rot_setting = val[1:0];
      pp4_pkg::CFG_RED_CODE: red_code = val;
      default:               white_code = val;
    endcase
  endtask

  // Sender: bursts of requests from the pending queue with random gaps
  always @(posedge clk) begin : sender
    plot_req_t nxt;
    int        burst_left;
    int        gap_left;
    if (rst) begin
      push       <= 1'b0;
      burst_left = int'($urandom_range(1, 40));
      gap_left   = 0;
    end else begin
      if (push && !full) plot_pixel_request(cur_req);
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          push <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          cur_req <= nxt;
          push    <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = int'($urandom_range(1, 40));
            if ($urandom_range(0, 3) == 0) gap_left = int'($urandom_range(5, 20));
            else gap_left = int'($urandom_range(0, 3));
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each popped pixel and stall on a pattern of its own
  always @(posedge clk) begin : receiver
    logic [7:0] want;
    int         hold_left;
    int         mode_left;
    int         rx_mode;
    bit         long_hold_done;
    if (rst) begin
      pop <= 1'b0;
      hold_left      = 0;
      mode_left      = 0;
      rx_mode        = 0;
      long_hold_done = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel_value, expected none, actual %0d",
                   $time, pixel_value);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_value !== want) begin
            $display("%0t: pixel_value mismatch, expected %0d, actual %0d",
                     $time, want, pixel_value);
            mismatch_count++;
          end
          pixels_checked++;
        end
      end
      // Hold off once for long enough to back the plotter up to its input
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else if (!long_hold_done && pixels_checked >= 40) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = int'($urandom_range(0, 3));
          mode_left = int'($urandom_range(8, 64));
        end else begin
          mode_left = mode_left - 1;
        end
        case (rx_mode)
          0, 1:    pop <= 1'b1;
          2:       pop <= 1'($urandom_range(0, 1));
          default: pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Watchdog: end the run if nothing is taken on any channel for too long
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  rot;
    logic [15:0] red;
    logic [15:0] white;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    rot_setting = pp4_pkg::ROTATION_RESET;
    red_code    = pp4_pkg::RED_CODE_RESET;
    white_code  = pp4_pkg::WHITE_CODE_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under reset settings: encodings, corners, misses
    queue_request(pp4_pkg::REQ_DRAW_RGB,  16'd0,     16'd0,     16'hE000, 4'd0);
    queue_request(pp4_pkg::REQ_DRAW_RGB,  16'd1,     16'd0,     16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_ROT,  16'd0,     16'd0,     16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_PHYS, 16'd1,     16'd0,     16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_DRAW_SAT,  16'd255,   16'd127,   16'hF800, 4'd15);
    queue_request(pp4_pkg::REQ_DRAW_SAT,  16'd254,   16'd127,   16'hFFFF, 4'd0);
    queue_request(pp4_pkg::REQ_DRAW_SAT,  16'd2,     16'd0,     16'h1234, 4'd6);
    queue_request(pp4_pkg::REQ_READ_PHYS, 16'd255,   16'd127,   16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_ROT,  16'd254,   16'd127,   16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_ROT,  16'd2,     16'd0,     16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_DRAW_RGB,  16'd256,   16'd0,     16'hE000, 4'd0);
    queue_request(pp4_pkg::REQ_DRAW_RGB,  16'hFFFF,  16'd0,     16'hE000, 4'd0);
    queue_request(pp4_pkg::REQ_DRAW_SAT,  16'd0,     16'd128,   16'hF800, 4'd15);
    queue_request(pp4_pkg::REQ_DRAW_RGB,  16'h8000,  16'h7FFF,  16'hE000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_PHYS, 16'd256,   16'd0,     16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_PHYS, 16'd0,     16'hFFFF,  16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_PHYS, 16'h8000,  16'h8000,  16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_PHYS, 16'h7FFF,  16'h7FFF,  16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_ROT,  16'd0,     16'd128,   16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_ROT,  16'hFFFF,  16'd5,     16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_READ_ROT,  16'd100,   16'd50,    16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_DRAW_RGB,  16'd3,     16'd0,     16'hFFFF, 4'd0);
    queue_request(pp4_pkg::REQ_READ_ROT,  16'd3,     16'd0,     16'h0000, 4'd0);
    queue_request(pp4_pkg::REQ_DRAW_RGB,  16'd4,     16'd1,     16'h001C, 4'd0);
    queue_request(pp4_pkg::REQ_READ_PHYS, 16'd4,     16'd1,     16'h0000, 4'd0);
    drain_plotter();

    // Random phases, each under its own register settings
    for (int p = 1; p <= 6; p++) begin
      case (p)
        1: begin rot = pp4_pkg::ROT_90;  red = 16'h0000; white = 16'hFFFF; end
        2: begin rot = pp4_pkg::ROT_180; red = 16'hFFFF; white = 16'h0000; end
        3: begin rot = pp4_pkg::ROT_270; red = 16'($urandom); white = red; end
        4: begin rot = pp4_pkg::ROT_0; red = 16'($urandom); white = 16'($urandom); end
        5: begin rot = 2'($urandom); red = 16'($urandom); white = 16'($urandom); end
        default: begin
          rot   = pp4_pkg::ROT_90;
          red   = pp4_pkg::RED_CODE_RESET;
          white = pp4_pkg::WHITE_CODE_RESET;
        end
      endcase
      write_config(pp4_pkg::CFG_ROTATION, {14'd0, rot});
      write_config(pp4_pkg::CFG_RED_CODE, red);
      write_config(pp4_pkg::CFG_WHITE_CODE, white);
      cfg_valid <= 1'b0;
      for (int n = 0; n < PHASE_REQS; n++) begin
        pending_reqs.push_back(random_request(rot, red, white));
      end
      drain_plotter();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[packed_4bpp_pixel_plotter.f]
rtl/pp4_pkg.sv
rtl/pp4_queue.sv
rtl/pp4_front.sv
rtl/pp4_back.sv
rtl/packed_4bpp_pixel_plotter.sv
dv/packed_4bpp_pixel_plotter_tb.sv
